// ===== rtl/core/wfgp_pkg.sv =====
// Shared types and constants of the wall-following grid path planner.
`default_nettype none
package wfgp_pkg;

  // Heading codes; the two top codes mark a hugger that has stopped
  localparam logic [2:0] DIR_N      = 3'd0;
  localparam logic [2:0] DIR_E      = 3'd1;
  localparam logic [2:0] DIR_S      = 3'd2;
  localparam logic [2:0] DIR_W      = 3'd3;
  localparam logic [2:0] DIR_FAILED = 3'd4;
  localparam logic [2:0] DIR_DONE   = 3'd5;

  // Register map
  localparam logic        REG_MAX_STEPS = 1'b0;
  localparam logic [15:0] MAX_STEPS_RST = 16'd1024;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LINIT,
    S_LOOP,
    S_LCHK,
    S_HSTEP,
    S_HCHK1,
    S_HCHK2,
    S_HREL,
    S_HPOST,
    S_HFAIL,
    S_TCHK,
    S_TRD,
    S_TWR,
    S_FINISH,
    S_ERD,
    S_EWT,
    S_EOUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/wfgp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wfgp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/wfgp_blk.sv =====
// Shared map unit: cell address decode and blocked-direction test.
`default_nettype none
module wfgp_blk import wfgp_pkg::*; #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128,
  parameter int CW         = 7,
  parameter int AW         = 14
) (
  input  logic [CW-1:0] nxt_x,
  input  logic [CW-1:0] nxt_y,
  output logic [AW-1:0] addr,
  output logic          nxt_in,
  input  logic [CW-1:0] cur_x,
  input  logic [CW-1:0] cur_y,
  input  logic [1:0]    dir,
  input  logic [3:0]    walls,
  output logic          blocked
);

  logic cur_in;
  logic edge_hit;

  // Decode the address of the cell probed next
  assign nxt_in = (32'(nxt_x) < MAP_WIDTH) && (32'(nxt_y) < MAP_HEIGHT);
  assign addr   = AW'(32'(nxt_y) * MAP_WIDTH + 32'(nxt_x));

  // Test the probed cell against its wall bits and the map edge
  assign cur_in = (32'(cur_x) < MAP_WIDTH) && (32'(cur_y) < MAP_HEIGHT);

  always_comb begin
    case (dir)
      DIR_N[1:0]: edge_hit = (cur_y == '0);
      DIR_E[1:0]: edge_hit = (32'(cur_x) == MAP_WIDTH - 1);
      DIR_S[1:0]: edge_hit = (32'(cur_y) == MAP_HEIGHT - 1);
      default:    edge_hit = (cur_x == '0);
    endcase
  end

  assign blocked = !cur_in || walls[dir] || edge_hit;

endmodule
`default_nettype wire

// ===== rtl/core/wfgp_seq.sv =====
// Path sequencer: line walk, two wall huggers, waypoint store and result emission.
`default_nettype none
module wfgp_seq import wfgp_pkg::*; #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128,
  parameter int MAX_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] max_steps,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_func,
  input  logic [6:0]  in_cell_x,
  input  logic [6:0]  in_cell_y,
  input  logic [3:0]  in_wall_bits,
  input  logic [6:0]  in_end_x,
  input  logic [6:0]  in_end_y,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [6:0]  out_point_x,
  output logic [6:0]  out_point_y,
  output logic        out_last,
  output logic        out_failed,
  output logic [15:0] out_step_count
);

  localparam int MW    = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
  localparam int CW    = ($clog2(MW) > 7) ? $clog2(MW) : 7;
  localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(MAX_POINTS);
  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int TAW   = LW + 1;

  state_t state_r, state_nxt;

  logic [AW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [CW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CW-1:0]   prb_x_r, prb_x_nxt, prb_y_r, prb_y_nxt;
  logic [CW:0]     acc_r, acc_nxt;
  logic [CW-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [1:0]      xdir_r, xdir_nxt, ydir_r, ydir_nxt, d_r, d_nxt;
  logic [15:0]     steps_r, steps_nxt;
  logic [PW-1:0]   plen_r, plen_nxt, ei_r, ei_nxt;
  logic            failed_r, failed_nxt;
  logic [CW-1:0]   hx_r [2];
  logic [CW-1:0]   hx_nxt [2];
  logic [CW-1:0]   hy_r [2];
  logic [CW-1:0]   hy_nxt [2];
  logic [2:0]      hd_r [2];
  logic [2:0]      hd_nxt [2];
  logic [LW-1:0]   hl_r [2];
  logic [LW-1:0]   hl_nxt [2];
  logic            hk_r, hk_nxt, dk_r, dk_nxt;
  logic [LW-1:0]   ti_r, ti_nxt;
  logic [6:0]      ox_r, ox_nxt, oy_r, oy_nxt;
  logic            olast_r, olast_nxt, ofail_r, ofail_nxt;
  logic [15:0]     ostep_r, ostep_nxt;

  // Map unit and memories
  logic [AW-1:0]   map_addr, map_waddr;
  logic            map_in, map_we, blocked;
  logic [3:0]      map_wdata, map_rdata;
  logic [1:0]      chk_dir;
  logic            way_we, app_en;
  logic [13:0]     app_data, way_rdata;
  logic            trail_we;
  logic [TAW-1:0]  trail_raddr;
  logic [13:0]     trail_rdata;

  // Selected hugger and derived conditions
  logic            in_acc;
  logic [CW-1:0]   sx, sy, dkx, dky;
  logic [2:0]      sd;
  logic [LW-1:0]   sl, dlen;
  logic [1:0]      side, turn;
  logic [CW:0]     mvx, mvy, h0mx, h0my;
  logic            tr_full, head_on, both_fail, steps_more, line_stop, trail_fit;
  logic            gx_gt, gy_gt, gx_eq, gy_eq, release_ok;
  logic [1:0]      xdir0, ydir0, xdir_i, ydir_i;
  logic            no1, no2, no3;

  assign in_acc = in_tvalid && in_tready;

  // One step in a direction, one bit wider so that a step off the low edge never aliases
  function automatic logic [CW:0] mv_x(input logic [CW-1:0] x, input logic [1:0] d);
    logic [CW:0] r;
    r = {1'b0, x};
    if (d == DIR_E[1:0]) r = r + 1'b1;
    else if (d == DIR_W[1:0]) r = r - 1'b1;
    return r;
  endfunction

  function automatic logic [CW:0] mv_y(input logic [CW-1:0] y, input logic [1:0] d);
    logic [CW:0] r;
    r = {1'b0, y};
    if (d == DIR_S[1:0]) r = r + 1'b1;
    else if (d == DIR_N[1:0]) r = r - 1'b1;
    return r;
  endfunction

  // Hugger under work and the hugger that released
  assign sx   = hk_r ? hx_r[1] : hx_r[0];
  assign sy   = hk_r ? hy_r[1] : hy_r[0];
  assign sd   = hk_r ? hd_r[1] : hd_r[0];
  assign sl   = hk_r ? hl_r[1] : hl_r[0];
  assign dkx  = dk_r ? hx_r[1] : hx_r[0];
  assign dky  = dk_r ? hy_r[1] : hy_r[0];
  assign dlen = dk_r ? hl_r[1] : hl_r[0];
  assign side = hk_r ? (sd[1:0] + 2'd1) : (sd[1:0] + 2'd3);
  assign turn = hk_r ? (sd[1:0] + 2'd3) : (sd[1:0] + 2'd1);
  assign mvx  = mv_x(sx, sd[1:0]);
  assign mvy  = mv_y(sy, sd[1:0]);
  assign tr_full = ({1'b0, sl} + 1'b1) > (LW+1)'(MAX_POINTS - 1);

  // Head-on meeting of the two huggers
  assign h0mx    = mv_x(hx_r[0], hd_r[0][1:0]);
  assign h0my    = mv_y(hy_r[0], hd_r[0][1:0]);
  assign head_on = (hd_r[0] <= DIR_W) && (h0mx == {1'b0, hx_r[1]}) &&
                   (h0my == {1'b0, hy_r[1]}) && ({1'b0, hd_r[0][1:0] + 2'd2} == hd_r[1]);
  assign both_fail  = (hd_r[0] == DIR_FAILED) && (hd_r[1] == DIR_FAILED);
  assign steps_more = (17'(steps_r) + 17'd1) < 17'(max_steps);
  assign line_stop  = (steps_r >= max_steps) || ((cur_x_r == goal_x_r) && (cur_y_r == goal_y_r));
  assign trail_fit  = ((PW+2)'(dlen) + (PW+2)'(plen_r) + (PW+2)'(2)) <= (PW+2)'(MAX_POINTS);

  // Line set-up from the current cell toward the goal
  assign gx_gt  = goal_x_r > cur_x_r;
  assign gy_gt  = goal_y_r > cur_y_r;
  assign gx_eq  = goal_x_r == cur_x_r;
  assign gy_eq  = goal_y_r == cur_y_r;
  assign xdir0  = gx_gt ? DIR_E[1:0] : DIR_W[1:0];
  assign ydir0  = gy_gt ? DIR_S[1:0] : DIR_N[1:0];
  assign xdir_i = gx_eq ? ydir0 : xdir0;
  assign ydir_i = gy_eq ? xdir_i : ydir0;

  // Release tests: wall plane, facing and progress since the hug began
  always_comb begin
    case (side)
      DIR_N[1:0]: no1 = goal_y_r < sy;
      DIR_E[1:0]: no1 = goal_x_r > sx;
      DIR_S[1:0]: no1 = goal_y_r > sy;
      default:    no1 = goal_x_r < sx;
    endcase
    case (sd[1:0])
      DIR_N[1:0]: no2 = goal_y_r > sy;
      DIR_E[1:0]: no2 = goal_x_r < sx;
      DIR_S[1:0]: no2 = goal_y_r < sy;
      default:    no2 = goal_x_r > sx;
    endcase
    no3 = ((cur_x_r <= goal_x_r) && ((sx < cur_x_r) || (sx > goal_x_r))) ||
          ((cur_x_r >= goal_x_r) && ((sx > cur_x_r) || (sx < goal_x_r))) ||
          ((cur_y_r <= goal_y_r) && ((sy < cur_y_r) || (sy > goal_y_r))) ||
          ((cur_y_r >= goal_y_r) && ((sy > cur_y_r) || (sy < goal_y_r))) ||
          ((sx == cur_x_r) && (sy == cur_y_r));
  end

  assign release_ok = !no1 && !no2 && !no3;

  // Waypoint append
  always_comb begin
    app_en   = 1'b0;
    app_data = {cur_y_r[6:0], cur_x_r[6:0]};
    case (state_r)
      S_LCHK:   app_en = blocked;
      S_HFAIL:  app_en = 1'b1;
      S_FINISH: app_en = (32'(plen_r) < MAX_POINTS - 2) && gx_eq && gy_eq;
      S_TWR: begin
        app_en   = 1'b1;
        app_data = trail_rdata;
      end
      S_TRD: begin
        app_en   = (ti_r == dlen);
        app_data = {dky[6:0], dkx[6:0]};
      end
      default: app_en = 1'b0;
    endcase
  end

  assign way_we = app_en && (32'(plen_r) < MAX_POINTS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (clr_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE:   if (in_acc && in_func) state_nxt = S_LINIT;
      S_LINIT:  state_nxt = S_LOOP;
      S_LOOP:   state_nxt = line_stop ? S_FINISH : S_LCHK;
      S_LCHK:   state_nxt = blocked ? S_HSTEP : S_LOOP;
      S_HSTEP:  state_nxt = (sd > DIR_W) ? S_HPOST : S_HCHK1;
      S_HCHK1: begin
        if (!blocked) state_nxt = S_HCHK2;
        else state_nxt = tr_full ? S_HPOST : S_HREL;
      end
      S_HCHK2:  state_nxt = (!blocked && tr_full) ? S_HPOST : S_HREL;
      S_HREL:   state_nxt = S_HPOST;
      S_HPOST: begin
        if (head_on) state_nxt = S_HFAIL;
        else if (!hk_r) state_nxt = S_HSTEP;
        else if (hd_r[0] == DIR_DONE || hd_r[1] == DIR_DONE) state_nxt = S_TCHK;
        else if (both_fail || !steps_more) state_nxt = S_HFAIL;
        else state_nxt = S_HSTEP;
      end
      S_HFAIL:  state_nxt = S_ERD;
      S_TCHK:   state_nxt = trail_fit ? S_TRD : S_HFAIL;
      S_TRD:    state_nxt = (ti_r == dlen) ? S_LINIT : S_TWR;
      S_TWR:    state_nxt = S_TRD;
      S_FINISH: state_nxt = S_ERD;
      S_ERD:    state_nxt = (plen_r == '0) ? S_EOUT : S_EWT;
      S_EWT:    state_nxt = S_EOUT;
      S_EOUT: begin
        if (out_tready) state_nxt = olast_r ? S_IDLE : S_ERD;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    clr_nxt = clr_r;   goal_x_nxt = goal_x_r; goal_y_nxt = goal_y_r;
    cur_x_nxt = cur_x_r; cur_y_nxt = cur_y_r;
    prb_x_nxt = prb_x_r; prb_y_nxt = prb_y_r;
    acc_nxt = acc_r; dx_nxt = dx_r; dy_nxt = dy_r;
    xdir_nxt = xdir_r; ydir_nxt = ydir_r; d_nxt = d_r;
    steps_nxt = steps_r; failed_nxt = failed_r; ei_nxt = ei_r;
    hx_nxt = hx_r; hy_nxt = hy_r; hd_nxt = hd_r; hl_nxt = hl_r;
    hk_nxt = hk_r; dk_nxt = dk_r; ti_nxt = ti_r;
    ox_nxt = ox_r; oy_nxt = oy_r; olast_nxt = olast_r; ofail_nxt = ofail_r;
    ostep_nxt = ostep_r;
    plen_nxt = way_we ? (plen_r + 1'b1) : plen_r;
    case (state_r)
      S_CLEAR: clr_nxt = clr_r + 1'b1;
      S_IDLE: begin
        prb_x_nxt = CW'(in_cell_x);
        prb_y_nxt = CW'(in_cell_y);
        if (in_acc && in_func) begin
          goal_x_nxt = CW'(in_end_x);
          goal_y_nxt = CW'(in_end_y);
          cur_x_nxt  = CW'(in_cell_x);
          cur_y_nxt  = CW'(in_cell_y);
          plen_nxt   = '0;
          steps_nxt  = '0;
        end
      end
      S_LINIT: begin
        xdir_nxt = xdir_i;
        ydir_nxt = ydir_i;
        dx_nxt   = gx_gt ? (goal_x_r - cur_x_r) : (cur_x_r - goal_x_r);
        dy_nxt   = gy_gt ? (goal_y_r - cur_y_r) : (cur_y_r - goal_y_r);
        acc_nxt  = (CW+1)'(dx_nxt >> 1) + (CW+1)'(dy_nxt >> 1);
      end
      S_LOOP: begin
        prb_x_nxt = cur_x_r;
        prb_y_nxt = cur_y_r;
        if (!line_stop) begin
          if (acc_r >= {1'b0, dx_r}) begin
            acc_nxt = acc_r - {1'b0, dx_r};
            d_nxt   = ydir_r;
          end else begin
            acc_nxt = acc_r + {1'b0, dy_r};
            d_nxt   = xdir_r;
          end
        end
      end
      S_LCHK: begin
        if (!blocked) begin
          cur_x_nxt = CW'(mv_x(cur_x_r, d_r));
          cur_y_nxt = CW'(mv_y(cur_y_r, d_r));
          steps_nxt = steps_r + 1'b1;
        end else begin
          hx_nxt[0] = cur_x_r; hx_nxt[1] = cur_x_r;
          hy_nxt[0] = cur_y_r; hy_nxt[1] = cur_y_r;
          hl_nxt[0] = '0;      hl_nxt[1] = '0;
          hd_nxt[0] = {1'b0, d_r + 2'd1};
          hd_nxt[1] = {1'b0, d_r + 2'd3};
          hk_nxt    = 1'b0;
        end
      end
      S_HSTEP: begin
        prb_x_nxt = sx;
        prb_y_nxt = sy;
      end
      S_HCHK1: begin
        if (blocked) begin
          hd_nxt[hk_r] = tr_full ? DIR_FAILED : {1'b0, turn};
          hl_nxt[hk_r] = sl + 1'b1;
        end else begin
          hx_nxt[hk_r] = CW'(mvx);
          hy_nxt[hk_r] = CW'(mvy);
          prb_x_nxt    = CW'(mvx);
          prb_y_nxt    = CW'(mvy);
        end
      end
      S_HCHK2: begin
        if (!blocked) begin
          hd_nxt[hk_r] = tr_full ? DIR_FAILED : {1'b0, side};
          hl_nxt[hk_r] = sl + 1'b1;
        end
      end
      S_HREL: begin
        if (release_ok) hd_nxt[hk_r] = DIR_DONE;
      end
      S_HPOST: begin
        if (!head_on) begin
          if (!hk_r) begin
            hk_nxt = 1'b1;
          end else if (hd_r[0] == DIR_DONE) begin
            dk_nxt = 1'b0;
          end else if (hd_r[1] == DIR_DONE) begin
            dk_nxt = 1'b1;
          end else if (!both_fail) begin
            steps_nxt = steps_r + 1'b1;
            hk_nxt    = 1'b0;
          end
        end
      end
      S_HFAIL: begin
        failed_nxt = 1'b1;
        ei_nxt     = '0;
      end
      S_TCHK: ti_nxt = '0;
      S_TRD: begin
        if (ti_r == dlen) begin
          cur_x_nxt = dkx;
          cur_y_nxt = dky;
          steps_nxt = steps_r + 1'b1;
        end
      end
      S_TWR: ti_nxt = ti_r + 1'b1;
      S_FINISH: begin
        failed_nxt = (32'(plen_r) >= MAX_POINTS - 2) || !(gx_eq && gy_eq);
        ei_nxt     = '0;
      end
      S_ERD: begin
        if (plen_r == '0) begin
          ox_nxt    = cur_x_r[6:0];
          oy_nxt    = cur_y_r[6:0];
          olast_nxt = 1'b1;
          ofail_nxt = 1'b1;
          ostep_nxt = steps_r;
        end
      end
      S_EWT: begin
        ox_nxt    = way_rdata[6:0];
        oy_nxt    = way_rdata[13:7];
        olast_nxt = (ei_r + 1'b1) == plen_r;
        ofail_nxt = failed_r;
        ostep_nxt = ((ei_r + 1'b1) == plen_r) ? steps_r : 16'd0;
      end
      S_EOUT: begin
        if (out_tready) ei_nxt = ei_r + 1'b1;
      end
      default: clr_nxt = clr_r;
    endcase
  end

  // Handshake and memory port controls
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_EOUT);
    trail_we   = 1'b0;
    case (state_r)
      S_HCHK1: trail_we = blocked;
      S_HCHK2: trail_we = !blocked;
      default: trail_we = 1'b0;
    endcase
    chk_dir = d_r;
    case (state_r)
      S_HCHK1: chk_dir = sd[1:0];
      S_HCHK2: chk_dir = side;
      default: chk_dir = d_r;
    endcase
    map_we    = (state_r == S_CLEAR) || (in_acc && !in_func && map_in);
    map_waddr = (state_r == S_CLEAR) ? clr_r : map_addr;
    map_wdata = (state_r == S_CLEAR) ? 4'd0 : in_wall_bits;
  end

  assign trail_raddr = {dk_r, ti_r};

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      plen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      plen_r  <= plen_nxt;
    end
    goal_x_r <= goal_x_nxt; goal_y_r <= goal_y_nxt;
    cur_x_r  <= cur_x_nxt;  cur_y_r  <= cur_y_nxt;
    prb_x_r  <= prb_x_nxt;  prb_y_r  <= prb_y_nxt;
    acc_r    <= acc_nxt;    dx_r     <= dx_nxt;   dy_r <= dy_nxt;
    xdir_r   <= xdir_nxt;   ydir_r   <= ydir_nxt; d_r  <= d_nxt;
    steps_r  <= steps_nxt;  ei_r     <= ei_nxt;
    failed_r <= failed_nxt;
    hx_r     <= hx_nxt;     hy_r     <= hy_nxt;
    hd_r     <= hd_nxt;     hl_r     <= hl_nxt;
    hk_r     <= hk_nxt;     dk_r     <= dk_nxt;   ti_r <= ti_nxt;
    ox_r     <= ox_nxt;     oy_r     <= oy_nxt;
    olast_r  <= olast_nxt;  ofail_r  <= ofail_nxt;
    ostep_r  <= ostep_nxt;
  end

  assign out_point_x    = ox_r;
  assign out_point_y    = oy_r;
  assign out_last       = olast_r;
  assign out_failed     = ofail_r;
  assign out_step_count = ostep_r;

  wfgp_blk #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .CW        (CW),
    .AW        (AW)
  ) u_blk (
    .nxt_x  (prb_x_nxt),
    .nxt_y  (prb_y_nxt),
    .addr   (map_addr),
    .nxt_in (map_in),
    .cur_x  (prb_x_r),
    .cur_y  (prb_y_r),
    .dir    (chk_dir),
    .walls  (map_rdata),
    .blocked(blocked)
  );

  wfgp_ram #(.WIDTH(4), .DEPTH(CELLS)) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .raddr(map_addr),
    .rdata(map_rdata)
  );

  wfgp_ram #(.WIDTH(14), .DEPTH(MAX_POINTS)) u_way (
    .clk  (clk),
    .we   (way_we),
    .waddr(plen_r[LW-1:0]),
    .wdata(app_data),
    .raddr(ei_r[LW-1:0]),
    .rdata(way_rdata)
  );

  wfgp_ram #(.WIDTH(14), .DEPTH(2 ** TAW)) u_trail (
    .clk  (clk),
    .we   (trail_we),
    .waddr({hk_r, sl}),
    .wdata({sy[6:0], sx[6:0]}),
    .raddr(trail_raddr),
    .rdata(trail_rdata)
  );

`ifndef SYNTH
  // Never take input while a result transaction is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during emission");

  // Waypoint count never passes the list depth
  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(plen_r) <= MAX_POINTS) else $error("waypoint count overflow");

  // Clearing pass hands over to idle once the last cell is written
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_r == AW'(CELLS - 1)) |=> (state_r == S_IDLE))
    else $error("clearing pass overran");

  // A trail copy only starts from a hugger that has released
  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TCHK) |-> (dk_r ? hd_r[1] == DIR_DONE : hd_r[0] == DIR_DONE))
    else $error("trail copy from a hugger that did not release");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/wall_following_grid_path_planner.sv =====
// Top level of the wall-following grid path planner: register port and stream channels.
//
// Usage: items arrive on the in_ stream. tuser selects the kind: 0 stores the four
// wall bits of one cell, 1 requests a path from the start cell to the end cell.
// A map write gives no result. A path request walks a line toward the goal one cell
// per map probe, hugging walls with two alternating huggers when blocked, and then
// sends its waypoints on the out_ stream, the last one flagged by tlast, with the
// step count on that last transaction. Line and hugger steps are paced by the
// single map read port that every blocked test goes through. Each waypoint is
// emitted through the read, wait and output states, the output state holding for
// any receiver stall. in_tready is low from acceptance of a path request until its
// last result transaction is taken. After reset the wall map is cleared one cell
// per cycle, all MAP_WIDTH*MAP_HEIGHT cells (16384 by default), before in_tready
// rises; max_steps resets to 1024 and may be written during that pass. A stalled
// receiver holds the result in the output register and the block waits.
`default_nettype none
module wall_following_grid_path_planner import wfgp_pkg::*; #(
  parameter int MAP_WIDTH  = 128,
  parameter int MAP_HEIGHT = 128,
  parameter int MAX_POINTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cell_x[6:0], cell_y[13:7], wall_bits[17:14],
                                  // end_x[24:18], end_y[31:25]
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // point_x[6:0], point_y[13:7], step_count[29:14], zero
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // failed[0]
);

  logic [15:0] max_steps_r, max_steps_nxt;
  logic        cfg_wr;
  logic [6:0]  px, py;
  logic [15:0] step_cnt;
  logic        fail;

  // Register port: one register, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_STEPS) ? {16'd0, max_steps_r} : 32'd0;

  always_comb begin
    max_steps_nxt = max_steps_r;
    if (cfg_wr && cfg_paddr[2] == REG_MAX_STEPS) max_steps_nxt = cfg_pwdata[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= MAX_STEPS_RST;
    end else begin
      max_steps_r <= max_steps_nxt;
    end
  end

  wfgp_seq #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .MAX_POINTS(MAX_POINTS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .max_steps     (max_steps_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_func       (in_tuser[0]),
    .in_cell_x     (in_tdata[6:0]),
    .in_cell_y     (in_tdata[13:7]),
    .in_wall_bits  (in_tdata[17:14]),
    .in_end_x      (in_tdata[24:18]),
    .in_end_y      (in_tdata[31:25]),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_point_x   (px),
    .out_point_y   (py),
    .out_last      (out_tlast),
    .out_failed    (fail),
    .out_step_count(step_cnt)
  );

  // Pack the result transaction
  assign out_tdata = {2'b00, step_cnt, py, px};
  assign out_tuser = fail;

endmodule
`default_nettype wire
